[hdl/gccp_pkg.sv]
// Shared types, widths, register indexes and sine table for the gravity-compensated current PID.
package gccp_pkg;

	localparam int COUNTS_PER_REV = 300;
	localparam int IDX_W          = $clog2(COUNTS_PER_REV + 1);

	localparam int CNT_W   = 16;
	localparam int MEAS_W  = 16;
	localparam int SINE_W  = 16;
	localparam int PROD_W  = 33;
	localparam int ERR_W   = 19;
	localparam int INTEG_W = 24;
	localparam int LAST_W  = 16;
	localparam int DERIV_W = 20;
	localparam int PP_W    = 33;
	localparam int PI_W    = 41;
	localparam int PD_W    = 37;
	localparam int SUM_W   = 42;
	localparam int INC_W   = 31;
	localparam int ACC_W   = 18;
	localparam int DRIVE_W = 9;
	localparam int ANGLE_W = 9;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// power of two so the pointers wrap by themselves
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P      = 3'd0,
		CFG_GAIN_I      = 3'd1,
		CFG_GAIN_D      = 3'd2,
		CFG_PEAK        = 3'd3,
		CFG_ERROR_LIMIT = 3'd4,
		CFG_DRIVE_LIMIT = 3'd5,
		CFG_DEAD_ZONE   = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic                     kind;
		logic                     encoder_b_level;
		logic signed [MEAS_W-1:0] measured_current;
	} in_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic [ANGLE_W-1:0]        angle_count;
		logic                      count_fault;
	} out_item_t;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [15:0] gravity_peak_current;
		logic [14:0] error_limit;
		logic [7:0]  drive_limit;
		logic [7:0]  dead_zone_counts;
	} cfg_t;

	// angle information carried alongside a tick through the pipeline
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             fault;
		logic             dead_zone;
	} tag_t;

	typedef struct packed {
		logic                     valid;
		logic signed [SINE_W-1:0] sine;
		logic signed [MEAS_W-1:0] meas;
		tag_t                     tag;
	} angle_stage_t;

	typedef logic signed [SINE_W-1:0] sine_rom_t [0:COUNTS_PER_REV];

	// Q14 polynomial sine of 2*pi*index/COUNTS_PER_REV
	function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned index);
		longint unsigned phase;
		longint unsigned quad;
		longint unsigned p;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned u;
		longint unsigned w;
		longint unsigned y;
		logic signed [SINE_W-1:0] r;
		phase = ((longint'(index) << 16) / COUNTS_PER_REV) & 64'hFFFF;
		quad  = (phase >> 14) & 64'd3;
		p     = phase & 64'h3FFF;
		x     = ((quad & 64'd1) != 0) ? (64'd16384 - p) : p;
		x2    = (x * x) >> 14;
		u     = 64'd10512 - ((64'd1160 * x2) >> 14);
		w     = 64'd25736 - ((x2 * u) >> 14);
		y     = (x * w) >> 14;
		r     = SINE_W'(y);
		return ((quad & 64'd2) != 0) ? -r : r;
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t t;
		for (int i = 0; i <= COUNTS_PER_REV; i++) begin
			t[i] = sine_entry(i);
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[hdl/gravity_compensated_current_pid.sv]
// Top level: configuration registers, input credit control and block wiring.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------
//   cfg     | in        | cfg_write            | cfg_index, cfg_data
//   in      | in        | in_valid / in_stall  | in_data (in_item_t)
//   out     | out       | out_valid / out_stall| out_data (out_item_t)
//
// One item is taken per cycle while in_stall is low. A control tick yields its result
// through the eight-stage angle/PID pipeline and then the result queue;
// encoder edges yield nothing.
// in_stall rises while FIFO_DEPTH tick results are in flight or queued, so a
// stalled output holds up the input only after the queue fills.
// Reset is asynchronous; no table clearing is needed after it.
module gravity_compensated_current_pid import gccp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	cfg_t              cfg_q;
	logic [PEND_W-1:0] pend_q;
	logic              in_accept;
	logic              tick_accept;
	logic              out_accept;
	angle_stage_t      angle_stage;
	logic              res_valid;
	out_item_t         res;

	assign in_stall    = (pend_q == PEND_W'(FIFO_DEPTH));
	assign in_accept   = in_valid & ~in_stall;
	assign tick_accept = in_accept & in_data.kind;
	assign out_accept  = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p               <= 16'd410;
			cfg_q.gain_i               <= 16'd0;
			cfg_q.gain_d               <= 16'd0;
			cfg_q.gravity_peak_current <= 16'd6277;
			cfg_q.error_limit          <= 15'd1280;
			cfg_q.drive_limit          <= 8'd255;
			cfg_q.dead_zone_counts     <= 8'd10;
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_GAIN_P:      cfg_q.gain_p               <= cfg_data;
				CFG_GAIN_I:      cfg_q.gain_i               <= cfg_data;
				CFG_GAIN_D:      cfg_q.gain_d               <= cfg_data;
				CFG_PEAK:        cfg_q.gravity_peak_current <= cfg_data;
				CFG_ERROR_LIMIT: cfg_q.error_limit          <= cfg_data[14:0];
				CFG_DRIVE_LIMIT: cfg_q.drive_limit          <= cfg_data[7:0];
				CFG_DEAD_ZONE:   cfg_q.dead_zone_counts     <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// count tick results not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (tick_accept && !out_accept) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_accept && !tick_accept) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	gccp_angle u_angle (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (in_accept),
		.item             (in_data),
		.dead_zone_counts (cfg_q.dead_zone_counts),
		.stage            (angle_stage)
	);

	gccp_pid u_pid (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.stage     (angle_stage),
		.res_valid (res_valid),
		.res       (res)
	);

	gccp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[hdl/gccp_angle.sv]
// Encoder position counter, per-tick wrap, and sine table lookup.
module gccp_angle import gccp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  in_item_t     item,
	input  logic [7:0]   dead_zone_counts,
	output angle_stage_t stage
);

	localparam logic signed [CNT_W-1:0] CPR_CNT = CNT_W'(COUNTS_PER_REV);
	localparam logic signed [CNT_W:0]   CPR_WIDE = (CNT_W + 1)'(COUNTS_PER_REV);

	logic signed [CNT_W-1:0]  count_q;
	logic signed [CNT_W-1:0]  wrapped;
	logic signed [CNT_W-1:0]  stepped;

	logic                     valid_s1;
	logic signed [CNT_W-1:0]  count_s1;
	logic signed [MEAS_W-1:0] meas_s1;

	logic signed [CNT_W:0]    count_wide;
	logic signed [CNT_W:0]    dz_wide;
	logic signed [CNT_W:0]    dz_upper;
	logic [IDX_W-1:0]         idx;
	tag_t                     tag;

	logic                     valid_s2;
	logic signed [SINE_W-1:0] sine_s2;
	logic signed [MEAS_W-1:0] meas_s2;
	tag_t                     tag_s2;

	// one wrap only; exactly one revolution stays as is
	always_comb begin
		if (count_q > CPR_CNT) begin
			wrapped = count_q - CPR_CNT;
		end else if (count_q < 0) begin
			wrapped = count_q + CPR_CNT;
		end else begin
			wrapped = count_q;
		end
		stepped = item.encoder_b_level ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept & item.kind;
			if (accept) begin
				count_q <= item.kind ? wrapped : stepped;
			end
		end
	end

	always_ff @(posedge clk) begin
		count_s1 <= wrapped;
		meas_s1  <= item.measured_current;
	end

	always_comb begin
		count_wide    = (CNT_W + 1)'(count_s1);
		dz_wide       = $signed((CNT_W + 1)'(dead_zone_counts));
		dz_upper      = CPR_WIDE - dz_wide;
		tag.fault     = (count_s1 < 0) || (count_s1 > CPR_CNT);
		tag.dead_zone = (count_wide < dz_wide) || (count_wide > dz_upper);
		if (count_s1 < 0) begin
			idx = '0;
		end else if (count_s1 > CPR_CNT) begin
			idx = IDX_W'(COUNTS_PER_REV);
		end else begin
			idx = count_s1[IDX_W-1:0];
		end
		tag.idx = idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sine_s2 <= SINE_ROM[idx];
		meas_s2 <= meas_s1;
		tag_s2  <= tag;
	end

	assign stage.valid = valid_s2;
	assign stage.sine  = sine_s2;
	assign stage.meas  = meas_s2;
	assign stage.tag   = tag_s2;

endmodule

[hdl/gccp_pid.sv]
// Desired current, error terms and incremental PID drive accumulation.
module gccp_pid import gccp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  angle_stage_t stage,
	output logic         res_valid,
	output out_item_t    res
);

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

	// pipeline valids
	logic valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, res_valid_q;

	// tick state
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [LAST_W-1:0]  last_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [MEAS_W-1:0]  meas_s3;
	tag_t                      tag_s3;

	logic [PROD_W-1:0]         mag;
	logic [PROD_W-1:0]         mag_rnd;
	logic signed [ERR_W-1:0]   des_mag;
	logic signed [ERR_W-1:0]   desired;
	logic signed [ERR_W-1:0]   err;

	logic signed [ERR_W-1:0]   err_s4;
	tag_t                      tag_s4;

	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_next;
	logic signed [DERIV_W-1:0] deriv;
	logic signed [ERR_W-1:0]   elim;
	logic signed [ERR_W-1:0]   err_clamped;

	logic signed [LAST_W-1:0]  ec_s5;
	logic signed [INTEG_W-1:0] integ_s5;
	logic signed [DERIV_W-1:0] deriv_s5;
	tag_t                      tag_s5;

	logic signed [PP_W-1:0]    pp_s6;
	logic signed [PI_W-1:0]    pi_s6;
	logic signed [PD_W-1:0]    pd_s6;
	tag_t                      tag_s6;

	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   sum_biased;

	logic signed [INC_W-1:0]   inc_s7;
	tag_t                      tag_s7;

	logic signed [INC_W:0]     acc_sum;
	logic signed [INC_W:0]     dlim;
	logic signed [INC_W:0]     acc_clamped;
	logic signed [ACC_W-1:0]   acc_next;
	logic signed [ACC_W-1:0]   acc_biased;

	out_item_t                 res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s3    <= stage.valid;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6;
			res_valid_q <= valid_s7;
		end
	end

	// peak current times sine
	always_ff @(posedge clk) begin
		prod_s3 <= $signed({1'b0, cfg.gravity_peak_current}) * stage.sine;
		meas_s3 <= stage.meas;
		tag_s3  <= stage.tag;
	end

	// round magnitude half up, restore sign, subtract measurement
	always_comb begin
		mag     = prod_s3[PROD_W-1] ? PROD_W'(-prod_s3) : PROD_W'(prod_s3);
		mag_rnd = mag + PROD_W'(8192);
		des_mag = $signed(ERR_W'(mag_rnd >> 14));
		desired = prod_s3[PROD_W-1] ? -des_mag : des_mag;
		err     = desired - ERR_W'(meas_s3);
	end

	always_ff @(posedge clk) begin
		err_s4 <= err;
		tag_s4 <= tag_s3;
	end

	// integral and derivative take the unclamped error
	always_comb begin
		integ_sum = (INTEG_W + 1)'(integ_q) + (INTEG_W + 1)'(err_s4);
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
		end else begin
			integ_next = integ_sum[INTEG_W-1:0];
		end
		deriv = DERIV_W'(err_s4) - DERIV_W'(last_q);
		elim  = $signed(ERR_W'(cfg.error_limit));
		if (err_s4 > elim) begin
			err_clamped = elim;
		end else if (err_s4 < -elim) begin
			err_clamped = -elim;
		end else begin
			err_clamped = err_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (valid_s4) begin
			integ_q <= integ_next;
			last_q  <= LAST_W'(err_clamped);
		end
	end

	always_ff @(posedge clk) begin
		ec_s5    <= LAST_W'(err_clamped);
		integ_s5 <= integ_next;
		deriv_s5 <= deriv;
		tag_s5   <= tag_s4;
	end

	always_ff @(posedge clk) begin
		pp_s6  <= $signed({1'b0, cfg.gain_p}) * ec_s5;
		pi_s6  <= $signed({1'b0, cfg.gain_i}) * integ_s5;
		pd_s6  <= $signed({1'b0, cfg.gain_d}) * deriv_s5;
		tag_s6 <= tag_s5;
	end

	// divide by 2048 toward zero
	always_comb begin
		sum        = SUM_W'(pp_s6) + SUM_W'(pi_s6) + SUM_W'(pd_s6);
		sum_biased = sum + (sum[SUM_W-1] ? SUM_W'(2047) : SUM_W'(0));
	end

	always_ff @(posedge clk) begin
		inc_s7 <= INC_W'(sum_biased >>> 11);
		tag_s7 <= tag_s6;
	end

	// accumulate, clamp, force zero in the dead zone
	always_comb begin
		acc_sum = (INC_W + 1)'(acc_q) + (INC_W + 1)'(inc_s7);
		dlim    = $signed((INC_W + 1)'({cfg.drive_limit, 9'd0}));
		if (acc_sum > dlim) begin
			acc_clamped = dlim;
		end else if (acc_sum < -dlim) begin
			acc_clamped = -dlim;
		end else begin
			acc_clamped = acc_sum;
		end
		acc_next   = tag_s7.dead_zone ? '0 : ACC_W'(acc_clamped);
		acc_biased = acc_next + (acc_next[ACC_W-1] ? ACC_W'(511) : ACC_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s7) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		res_q.drive       <= DRIVE_W'(acc_biased >>> 9);
		res_q.angle_count <= ANGLE_W'(tag_s7.idx);
		res_q.count_fault <= tag_s7.fault;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[hdl/gccp_result_fifo.sv]
// Result queue between the PID pipeline and the output channel.
module gccp_result_fifo import gccp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	out_item_t         entries [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [PEND_W-1:0] count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign out_data  = entries[rd_q];
	assign pop       = out_valid & ~out_stall;

	// upstream credit count keeps push away from a full queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_q] <= push_data;
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the gravity-compensated current PID block.
module testbench;
	import gccp_pkg::*;

	localparam longint REV          = COUNTS_PER_REV;
	localparam int     CYCLE_LIMIT  = 60000;
	localparam int     DRAIN_CYCLES = 14;
	localparam int     HOLD_CYCLES  = 80;
	localparam int     PHASE_ITEMS  = 10;
	localparam int     SAT_TICKS    = 90;
	localparam logic   KIND_EDGE    = 1'b0;
	localparam logic   KIND_TICK    = 1'b1;
	localparam longint INTEG_TOP    = 64'sd8388607;
	localparam longint INTEG_BOTTOM = -64'sd8388608;

	typedef struct packed {
		in_item_t    item;
		logic [16:0] reps;
		logic        typed;
		out_item_t   want;
	} step_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;

	// current-loop model state and register copy
	logic signed [15:0] enc_pos;
	longint             drv_acc;
	longint             err_sum;
	longint             prev_err;
	cfg_t               regs;

	out_item_t expected_drives[$];
	out_item_t oldest;
	step_row_t steps[$];
	int        errors;
	int        cycles;
	int        send_idle_pct;
	int        stall_pct;
	bit        hold_req;
	int        hold_left;

	gravity_compensated_current_pid i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Q14 sine of 2*pi*idx/REV from the polynomial approximation
	function automatic longint sine_q14(longint idx);
		longint ph, quad, frac, x, sq, poly, lin, y;
		ph   = ((idx << 16) / REV) & 64'hFFFF;
		quad = ph >> 14;
		frac = ph & 64'h3FFF;
		x    = ((quad & 1) != 0) ? (16384 - frac) : frac;
		sq   = (x * x) >> 14;
		poly = 10512 - ((1160 * sq) >> 14);
		lin  = 25736 - ((sq * poly) >> 14);
		y    = (x * lin) >> 14;
		return ((quad & 2) != 0) ? -y : y;
	endfunction

	function automatic longint trunc_shift(longint v, int sh);
		return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
	endfunction

	task automatic step_current_loop(input in_item_t it, output bit made, output out_item_t res);
		longint pos, idx, prod, mag, wanted, meas, err, deriv, lim, inc, acc, span, dz;
		bit     fault;
		made = 1'b0;
		res  = '0;
		if (it.kind == KIND_EDGE) begin
			if (it.encoder_b_level)
				enc_pos = enc_pos + 16'sd1;
			else
				enc_pos = enc_pos - 16'sd1;
			return;
		end
		pos = enc_pos;
		if (pos > REV)
			pos = pos - REV;
		else if (pos < 0)
			pos = pos + REV;
		enc_pos = pos[15:0];
		pos     = enc_pos;
		fault   = (pos < 0) || (pos > REV);
		idx     = (pos < 0) ? 0 : ((pos > REV) ? REV : pos);

		prod   = longint'(regs.gravity_peak_current) * sine_q14(idx);
		mag    = (prod < 0) ? -prod : prod;
		mag    = (mag + 8192) >>> 14;
		wanted = (prod < 0) ? -mag : mag;
		meas   = $signed(it.measured_current);
		err    = wanted - meas;

		// integral and derivative see the unclamped error
		err_sum = err_sum + err;
		if (err_sum > INTEG_TOP)
			err_sum = INTEG_TOP;
		if (err_sum < INTEG_BOTTOM)
			err_sum = INTEG_BOTTOM;
		deriv = err - prev_err;
		lim   = longint'(regs.error_limit);
		if (err > lim)
			err = lim;
		else if (err < -lim)
			err = -lim;
		prev_err = err;

		inc = longint'(regs.gain_p) * err + longint'(regs.gain_i) * err_sum +
			longint'(regs.gain_d) * deriv;
		inc  = trunc_shift(inc, 11);
		acc  = drv_acc + inc;
		span = longint'(regs.drive_limit) * 512;
		if (acc > span)
			acc = span;
		else if (acc < -span)
			acc = -span;
		dz = longint'(regs.dead_zone_counts);
		if (pos < dz || pos > REV - dz)
			acc = 0;
		drv_acc = acc;

		res.drive       = DRIVE_W'(trunc_shift(acc, 9));
		res.angle_count = ANGLE_W'(idx);
		res.count_fault = fault;
		made = 1'b1;
	endtask

	function automatic in_item_t make_item(logic kind, logic b, logic [15:0] meas);
		in_item_t it;
		it.kind             = kind;
		it.encoder_b_level  = b;
		it.measured_current = meas;
		return it;
	endfunction

	function automatic void add_row(logic kind, logic b, logic [15:0] meas, int reps,
		logic typed, int drive, int angle, logic fault);
		step_row_t row;
		row.item              = make_item(kind, b, meas);
		row.reps              = 17'(reps);
		row.typed             = typed;
		row.want.drive        = DRIVE_W'(drive);
		row.want.angle_count  = ANGLE_W'(angle);
		row.want.count_fault  = fault;
		steps.push_back(row);
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_drives.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: drive %0d angle %0d fault %0d",
					$time, $signed(out_data.drive), out_data.angle_count,
					out_data.count_fault);
			end else begin
				oldest = expected_drives.pop_front();
				check_field("drive", $signed(oldest.drive), $signed(out_data.drive));
				check_field("angle_count", oldest.angle_count, out_data.angle_count);
				check_field("count_fault", oldest.count_fault, out_data.count_fault);
			end
		end
	end

	// output stall: random, or a long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
		bit        made;
		out_item_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		step_current_loop(it, made, res);
		if (made)
			expected_drives.push_back(typed ? want : res);
	endtask

	task automatic send(input in_item_t it);
		offer(it, 1'b0, '0);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_drives.size() != 0)
			@(posedge clk);
		// edges leave no result, so give the pipeline time to empty
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input cfg_t s);
		cfg_index_t sel;
		settle();
		sel = sel.first();
		forever begin
			@(negedge clk);
			cfg_write <= 1'b1;
			cfg_index <= sel;
			case (sel)
				CFG_GAIN_P:      cfg_data <= s.gain_p;
				CFG_GAIN_I:      cfg_data <= s.gain_i;
				CFG_GAIN_D:      cfg_data <= s.gain_d;
				CFG_PEAK:        cfg_data <= s.gravity_peak_current;
				CFG_ERROR_LIMIT: cfg_data <= {1'b0, s.error_limit};
				CFG_DRIVE_LIMIT: cfg_data <= {8'd0, s.drive_limit};
				default:         cfg_data <= {8'd0, s.dead_zone_counts};
			endcase
			if (sel == sel.last())
				break;
			sel = sel.next();
		end
		@(negedge clk);
		cfg_write <= 1'b0;
		regs = s;
	endtask

	task automatic steer_to(input longint target);
		while (enc_pos != target)
			send(make_item(KIND_EDGE, enc_pos < target, 16'($urandom)));
	endtask

	initial begin
		cfg_t setting;
		int   n;
		int   len;
		logic dir;
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = CFG_GAIN_P;
		cfg_data      = '0;
		in_valid      = 1'b0;
		in_data       = '0;
		errors        = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 1'b0;
		enc_pos       = '0;
		drv_acc       = 0;
		err_sum       = 0;
		prev_err      = 0;
		regs          = {16'd410, 16'd0, 16'd0, 16'd6277, 15'd1280, 8'd255, 8'd10};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// count at zero lies in the dead zone
		add_row(KIND_TICK, 1'b0, 16'h0000, 1, 1'b1, 0, 0, 1'b0);
		add_row(KIND_TICK, 1'b1, 16'h7FFF, 1, 1'b1, 0, 0, 1'b0);
		add_row(KIND_TICK, 1'b0, 16'h8000, 1, 1'b1, 0, 0, 1'b0);
		// one step below zero wraps to the top of the revolution
		add_row(KIND_EDGE, 1'b0, 16'h7FFF, 1, 1'b0, 0, 0, 1'b0);
		add_row(KIND_TICK, 1'b1, 16'h0100, 1, 1'b1, 0, 299, 1'b0);
		// exactly one revolution: no wrap
		add_row(KIND_EDGE, 1'b1, 16'h8000, 1, 1'b0, 0, 0, 1'b0);
		add_row(KIND_TICK, 1'b0, 16'h0100, 1, 1'b1, 0, 300, 1'b0);
		add_row(KIND_EDGE, 1'b1, 16'h0000, 1, 1'b0, 0, 0, 1'b0);
		add_row(KIND_TICK, 1'b0, 16'h0100, 1, 1'b1, 0, 1, 1'b0);
		// below zero by more than a revolution: fault, index clamped low
		add_row(KIND_EDGE, 1'b0, 16'hFFFF, 302, 1'b0, 0, 0, 1'b0);
		add_row(KIND_TICK, 1'b0, 16'h0100, 1, 1'b1, 0, 0, 1'b1);
		add_row(KIND_TICK, 1'b0, 16'h0100, 1, 1'b1, 0, 299, 1'b0);

		foreach (steps[k])
			repeat (steps[k].reps) offer(steps[k].item, steps[k].typed, steps[k].want);

		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 29 : ((ph < 4) ? 86 : 0);
			stall_pct     = (ph < 2) ? 86 : ((ph < 4) ? 29 : 0);
			case (ph)
				0: setting = {16'd410, 16'd0, 16'd0, 16'd6277, 15'd1280, 8'd255, 8'd10};
				1: setting = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 8'd255, 8'd0};
				2: setting = {16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 8'd0, 8'd150};
				4: setting = {16'd800, 16'd30, 16'd2000, 16'd6277, 15'd2560, 8'd200, 8'd5};
				default: begin
					setting.gain_p               = 16'($urandom_range(65535));
					setting.gain_i               = 16'($urandom_range(65535));
					setting.gain_d               = 16'($urandom_range(65535));
					setting.gravity_peak_current = 16'($urandom_range(65535));
					setting.error_limit          = 15'($urandom_range(32767));
					setting.drive_limit          = 8'($urandom_range(255));
					setting.dead_zone_counts     = 8'($urandom_range(150));
				end
			endcase
			apply_setting(setting);

			if (ph == 1) begin
				// hold the output off while ticks pile up, and drive the integral
				// into its lower saturation limit
				steer_to(225);
				hold_req = 1'b1;
				repeat (SAT_TICKS)
					send(make_item(KIND_TICK, 1'($urandom_range(1)), 16'h7FFF));
			end

			n = 0;
			while (n < PHASE_ITEMS) begin
				case ($urandom_range(99)) inside
					[0:9]: begin
						if (enc_pos > 250)
							dir = 1'b0;
						else if (enc_pos < 50)
							dir = 1'b1;
						else
							dir = 1'($urandom_range(1));
						len = $urandom_range(40, 5);
						repeat (len) send(make_item(KIND_EDGE, dir, 16'($urandom)));
						n += len;
					end
					[10:54]: begin
						send(make_item(KIND_EDGE, 1'($urandom_range(1)), 16'($urandom)));
						n++;
					end
					default: begin
						if ($urandom_range(1))
							send(make_item(KIND_TICK, 1'($urandom_range(1)),
								16'($urandom)));
						else
							send(make_item(KIND_TICK, 1'($urandom_range(1)),
								16'($urandom_range(6000)) - 16'd3000));
						n++;
					end
				endcase
			end
		end

		settle();
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
